// ===== sv/apl_pkg.sv =====
// ----------------------------------------------------------------------------
// apl_pkg: shared types, constants and microcode for the peak limiter
// Formats, register indexes, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int ENV_W      = 40;   // envelope, LSB = 2^-36
  localparam int COEF_W     = 24;   // Q0.24 coefficients and gain
  localparam int ENV_EXTRA  = 16;   // extra fraction bits of the envelope
  localparam int CEIL_SHIFT = 12;   // Q0.24 ceiling to envelope scale
  localparam int FRAC_BITS  = 20;   // Q3.20 sample
  localparam int OUT_W      = 22;
  localparam int HALF_W     = ENV_W / 2;
  localparam int CNT_W      = $clog2(COEF_W);
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 4;

  localparam logic [COEF_W-1:0] CEILING_RST = 24'd10066330;
  localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd4194304;
  localparam logic [COEF_W-1:0] RELEASE_RST = 24'd1678;

  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_TARGET,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_UPDATE,
    OP_CHECK,
    OP_DIV,
    OP_SCALE_MUL,
    OP_SCALE,
    OP_OUTPUT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_IN_VALID,
    COND_NOT_OVER,
    COND_CNT_ZERO,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic              stay;    // hold the step while the condition is false
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic over;
    logic cnt_zero;
    logic out_free;
  } status_t;

  localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TARGET = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_LO = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_HI = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SUM    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_UPDATE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DIV    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SMUL   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_OUTPUT = 4'd11;

  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, stay: 1'b0, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT:   w = '{op: OP_LOAD,      cond: COND_IN_VALID, stay: 1'b1,
                         target: STEP_TARGET};
      STEP_TARGET: w = '{op: OP_TARGET,    cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_DIFF:   w = '{op: OP_DIFF,      cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_MUL_LO: w = '{op: OP_MUL_LO,    cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_MUL_HI: w = '{op: OP_MUL_HI,    cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_SUM:    w = '{op: OP_SUM,       cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_UPDATE: w = '{op: OP_UPDATE,    cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_CHECK:  w = '{op: OP_CHECK,     cond: COND_NOT_OVER, stay: 1'b0,
                         target: STEP_OUTPUT};
      STEP_DIV:    w = '{op: OP_DIV,       cond: COND_CNT_ZERO, stay: 1'b1,
                         target: STEP_SMUL};
      STEP_SMUL:   w = '{op: OP_SCALE_MUL, cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_SCALE:  w = '{op: OP_SCALE,     cond: COND_NONE, stay: 1'b0,
                         target: STEP_WAIT};
      STEP_OUTPUT: w = '{op: OP_OUTPUT,    cond: COND_OUT_FREE, stay: 1'b1,
                         target: STEP_WAIT};
      default:     w = '{op: OP_NOP,       cond: COND_ALWAYS, stay: 1'b0,
                         target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/audio_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// audio_peak_limiter: envelope-following peak limiter
// Microcoded control over a datapath with one multiplier and a 1-bit divider.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  input    | in        | in_valid_i/in_stall_o  | sample_in_i, block_end_i
//  output   | out       | out_valid_o/out_stall_i| sample_out_o, gain_reduced_o,
//           |           |                        | block_end_out_o
//  config   | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
//  A request takes longer when the envelope is above the ceiling than when it
//  stays at or below it: the gain divider then produces one quotient bit per
//  cycle over the 24 quotient bits. One request is in work at a time;
//  the next is accepted once the previous result is loaded into the output
//  register. Reset clears the envelope and loads the default registers.
//  A stalled result holds the sequencer in its output step.
module audio_peak_limiter #(
  parameter int SAMPLE_WIDTH = apl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [apl_pkg::OUT_W-1:0]    sample_out_o,
  output logic                                gain_reduced_o,
  output logic                                block_end_out_o,
  input  logic                                cfg_we_i,
  input  logic [apl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [apl_pkg::COEF_W-1:0]          cfg_data_i
);
  import apl_pkg::*;

  logic [COEF_W-1:0] ceiling_q, attack_q, release_q;
  ctrl_t             ctrl;
  status_t           status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CEILING_RST;
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CEILING: ceiling_q <= cfg_data_i;
        CFG_ATTACK:  attack_q  <= cfg_data_i;
        CFG_RELEASE: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  apl_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  apl_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .ceiling_i       (ceiling_q),
    .attack_coef_i   (attack_q),
    .release_coef_i  (release_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .gain_reduced_o  (gain_reduced_o),
    .block_end_out_o (block_end_out_o)
  );

endmodule

// ===== sv/apl_seq.sv =====
// ----------------------------------------------------------------------------
// apl_seq: microprogram sequencer
// Step counter over the control ROM with conditional jumps and wait steps.
// ----------------------------------------------------------------------------
module apl_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  apl_pkg::status_t status_i,
  output apl_pkg::ctrl_t   ctrl_o
);
  import apl_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             ctrl;
  logic              take;

  assign ctrl   = ucode_rom(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_IN_VALID: take = status_i.in_valid;
      COND_NOT_OVER: take = !status_i.over;
      COND_CNT_ZERO: take = status_i.cnt_zero;
      COND_OUT_FREE: take = status_i.out_free;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      step_d = ctrl.target;
    end else if (ctrl.stay) begin
      step_d = step_q;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== sv/apl_dp.sv =====
// ----------------------------------------------------------------------------
// apl_dp: limiter datapath
// Envelope, shared multiplier, radix-2 gain divider, clip and result register.
// ----------------------------------------------------------------------------
module apl_dp #(
  parameter int SAMPLE_WIDTH = apl_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  apl_pkg::ctrl_t                      ctrl_i,
  output apl_pkg::status_t                    status_o,
  input  logic [apl_pkg::COEF_W-1:0]          ceiling_i,
  input  logic [apl_pkg::COEF_W-1:0]          attack_coef_i,
  input  logic [apl_pkg::COEF_W-1:0]          release_coef_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [apl_pkg::OUT_W-1:0]    sample_out_o,
  output logic                                gain_reduced_o,
  output logic                                block_end_out_o
);
  import apl_pkg::*;

  localparam int W    = SAMPLE_WIDTH;
  localparam int MA   = (W > HALF_W) ? W : HALF_W;     // multiplier operand A
  localparam int PW   = MA + COEF_W;
  localparam int EPW  = HALF_W + COEF_W;               // envelope partial product
  localparam int AW   = 2 * HALF_W + COEF_W;           // envelope product sum
  localparam int TW   = (W + ENV_EXTRA > ENV_W) ? W + ENV_EXTRA : ENV_W;
  localparam int CW   = ((W > OUT_W) ? W : OUT_W) + 1;
  localparam logic signed [CW-1:0] ONE_C = CW'(1 << FRAC_BITS);

  logic signed [W-1:0]  s_q;
  logic [W-1:0]         mag_q;
  logic                 blk_q;
  logic [ENV_W-1:0]     target_q, env_q, diff_q, rem_q;
  logic                 up_q, reduced_q;
  logic [PW-1:0]        prod_q;
  logic [AW-1:0]        acc_q;
  logic [COEF_W-1:0]    quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q, gain_red_q, blk_out_q;
  logic signed [OUT_W-1:0] out_q;

  logic [TW-1:0]        tgt_wide;
  logic [ENV_W-1:0]     tgt_sat;
  logic [ENV_W-1:0]     ceil_ext;
  logic                 over;
  logic [MA-1:0]        mul_a;
  logic [COEF_W-1:0]    mul_b, coef;
  logic [PW-1:0]        prod_d;
  logic [ENV_W-1:0]     delta;
  logic [ENV_W:0]       rem_sh;
  logic                 rem_ge;
  logic [W-1:0]         scaled;
  logic signed [CW-1:0] s_ext, s_clip;
  logic                 clip;
  logic                 out_free;

  assign ceil_ext = {{(ENV_W - COEF_W - CEIL_SHIFT){1'b0}}, ceiling_i, {CEIL_SHIFT{1'b0}}};
  assign over     = env_q > ceil_ext;
  assign out_free = !out_valid_q || !out_stall_i;

  assign tgt_wide = TW'(mag_q) << ENV_EXTRA;
  assign tgt_sat  = (tgt_wide > TW'({ENV_W{1'b1}})) ? {ENV_W{1'b1}} : tgt_wide[ENV_W-1:0];

  // one shared multiplier: envelope step in two halves, then sample scaling
  assign coef = up_q ? attack_coef_i : release_coef_i;
  always_comb begin
    case (ctrl_i.op)
      OP_MUL_LO: begin
        mul_a = MA'(diff_q[HALF_W-1:0]);
        mul_b = coef;
      end
      OP_MUL_HI: begin
        mul_a = MA'(diff_q[ENV_W-1:HALF_W]);
        mul_b = coef;
      end
      default: begin
        mul_a = MA'(mag_q);
        mul_b = quo_q;
      end
    endcase
  end
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  assign delta  = acc_q[COEF_W +: ENV_W];
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, env_q};
  assign scaled = prod_q[COEF_W +: W];

  assign s_ext  = CW'(s_q);
  always_comb begin
    if (s_ext > ONE_C) begin
      s_clip = ONE_C;
      clip   = 1'b1;
    end else if (s_ext < -ONE_C) begin
      s_clip = -ONE_C;
      clip   = 1'b1;
    end else begin
      s_clip = s_ext;
      clip   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        s_q   <= sample_in_i;
        mag_q <= sample_in_i[W-1] ? W'(-sample_in_i) : W'(sample_in_i);
        blk_q <= block_end_i;
      end
      OP_TARGET: target_q <= tgt_sat;
      OP_DIFF: begin
        up_q   <= target_q > env_q;
        diff_q <= (target_q > env_q) ? target_q - env_q : env_q - target_q;
      end
      OP_MUL_LO: prod_q <= prod_d;
      OP_MUL_HI: begin
        acc_q  <= AW'(prod_q[EPW-1:0]);
        prod_q <= prod_d;
      end
      OP_SUM: acc_q <= acc_q + (AW'(prod_q[EPW-1:0]) << HALF_W);
      OP_CHECK: begin
        reduced_q <= over;
        rem_q     <= ceil_ext;
        quo_q     <= '0;
        cnt_q     <= CNT_W'(COEF_W - 1);
      end
      OP_DIV: begin
        rem_q <= rem_ge ? rem_sh[ENV_W-1:0] - env_q : rem_sh[ENV_W-1:0];
        quo_q <= {quo_q[COEF_W-2:0], rem_ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      OP_SCALE_MUL: prod_q <= prod_d;
      OP_SCALE: s_q <= s_q[W-1] ? -$signed(scaled) : $signed(scaled);
      default: ;
    endcase
    if (ctrl_i.op == OP_OUTPUT && out_free) begin
      out_q      <= s_clip[OUT_W-1:0];
      gain_red_q <= reduced_q | clip;
      blk_out_q  <= blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_UPDATE) begin
        env_q <= up_q ? env_q + delta : env_q - delta;
      end
      if (ctrl_i.op == OP_OUTPUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o = '{in_valid: in_valid_i, over: over,
                      cnt_zero: cnt_q == '0, out_free: out_free};

  assign in_stall_o      = ctrl_i.op != OP_LOAD;
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;
  assign gain_reduced_o  = gain_red_q;
  assign block_end_out_o = blk_out_q;

endmodule
